/* rtl/blsp_pkg.sv */
package blsp_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 12;

   // fixed field widths
   localparam int DIM_BITS   = 9;
   localparam int COLOR_BITS = 8;
   localparam int INDEX_BITS = 16;

   // cell word contents
   localparam logic [7:0] GLYPH_BLOCK = 8'd219;

   // register reset values
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 9'd80;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 9'd25;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_BITS  = 1;
   localparam int Q_CNT_BITS  = 2;

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_ADVANCE = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } csr_reg_type;

   // back end status seen by the top level
   typedef struct packed {
      logic active;
      logic out_stall;
   } status_type;

endpackage

/* rtl/blsp_front.sv */
module blsp_front #(
   parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF,
   parameter int REQ_DATA_W = ((4 * COORD_BITS + blsp_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // command
   // x_start, y_start, x_end, y_end, color
   input  logic [REQ_DATA_W-1:0]               req_tdata,
   output logic                                q_valid,
   input  logic                                q_pop,
   output blsp_pkg::cmd_type                   q_cmd,
   output logic [COORD_BITS-1:0]               q_x0,
   output logic [COORD_BITS-1:0]               q_y0,
   output logic [COORD_BITS-1:0]               q_x1,
   output logic [COORD_BITS-1:0]               q_y1,
   output logic [COORD_BITS:0]                 q_dx,
   output logic [COORD_BITS:0]                 q_dy,
   output logic                                q_sxn,
   output logic                                q_syn,
   output logic [blsp_pkg::COLOR_BITS-1:0]     q_color
);

   localparam int C = COORD_BITS;

   logic [C-1:0] in_x0, in_y0, in_x1, in_y1;
   logic [blsp_pkg::COLOR_BITS-1:0] in_color;
   logic signed [C:0] diff_x, diff_y;
   logic [C:0] abs_x, abs_y;
   logic neg_x, neg_y;
   logic push;

   blsp_pkg::cmd_type entry_cmd_ff [blsp_pkg::QUEUE_DEPTH];
   logic [C-1:0] entry_x0_ff [blsp_pkg::QUEUE_DEPTH];
   logic [C-1:0] entry_y0_ff [blsp_pkg::QUEUE_DEPTH];
   logic [C-1:0] entry_x1_ff [blsp_pkg::QUEUE_DEPTH];
   logic [C-1:0] entry_y1_ff [blsp_pkg::QUEUE_DEPTH];
   logic [C:0] entry_dx_ff [blsp_pkg::QUEUE_DEPTH];
   logic [C:0] entry_dy_ff [blsp_pkg::QUEUE_DEPTH];
   logic entry_sxn_ff [blsp_pkg::QUEUE_DEPTH];
   logic entry_syn_ff [blsp_pkg::QUEUE_DEPTH];
   logic [blsp_pkg::COLOR_BITS-1:0] entry_color_ff [blsp_pkg::QUEUE_DEPTH];

   logic [blsp_pkg::Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [blsp_pkg::Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [blsp_pkg::Q_CNT_BITS-1:0] count_ff, count_in;

   // unpack the word
   assign in_x0    = req_tdata[C-1:0];
   assign in_y0    = req_tdata[2*C-1:C];
   assign in_x1    = req_tdata[3*C-1:2*C];
   assign in_y1    = req_tdata[4*C-1:3*C];
   assign in_color = req_tdata[4*C+blsp_pkg::COLOR_BITS-1:4*C];

   // span and direction of a start, worked out on entry
   always_comb begin
      diff_x = $signed({in_x1[C-1], in_x1}) - $signed({in_x0[C-1], in_x0});
      diff_y = $signed({in_y1[C-1], in_y1}) - $signed({in_y0[C-1], in_y0});
      abs_x  = diff_x[C] ? (C+1)'(-diff_x) : (C+1)'(diff_x);
      abs_y  = diff_y[C] ? (C+1)'(-diff_y) : (C+1)'(diff_y);
      neg_x  = diff_x[C] || (diff_x == '0);
      neg_y  = diff_y[C] || (diff_y == '0);
   end

   // queue handshake
   assign req_tready = (count_ff != (blsp_pkg::Q_CNT_BITS)'(blsp_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_cmd_ff[wr_ptr_ff]   <= blsp_pkg::cmd_type'(req_tuser);
         entry_x0_ff[wr_ptr_ff]    <= in_x0;
         entry_y0_ff[wr_ptr_ff]    <= in_y0;
         entry_x1_ff[wr_ptr_ff]    <= in_x1;
         entry_y1_ff[wr_ptr_ff]    <= in_y1;
         entry_dx_ff[wr_ptr_ff]    <= abs_x;
         entry_dy_ff[wr_ptr_ff]    <= abs_y;
         entry_sxn_ff[wr_ptr_ff]   <= neg_x;
         entry_syn_ff[wr_ptr_ff]   <= neg_y;
         entry_color_ff[wr_ptr_ff] <= in_color;
      end
   end

   // head of the queue
   assign q_cmd   = entry_cmd_ff[rd_ptr_ff];
   assign q_x0    = entry_x0_ff[rd_ptr_ff];
   assign q_y0    = entry_y0_ff[rd_ptr_ff];
   assign q_x1    = entry_x1_ff[rd_ptr_ff];
   assign q_y1    = entry_y1_ff[rd_ptr_ff];
   assign q_dx    = entry_dx_ff[rd_ptr_ff];
   assign q_dy    = entry_dy_ff[rd_ptr_ff];
   assign q_sxn   = entry_sxn_ff[rd_ptr_ff];
   assign q_syn   = entry_syn_ff[rd_ptr_ff];
   assign q_color = entry_color_ff[rd_ptr_ff];

endmodule

/* rtl/blsp_back.sv */
module blsp_back #(
   parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [blsp_pkg::DIM_BITS-1:0]       screen_width,
   input  logic [blsp_pkg::DIM_BITS-1:0]       screen_height,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  blsp_pkg::cmd_type                   q_cmd,
   input  logic [COORD_BITS-1:0]               q_x0,
   input  logic [COORD_BITS-1:0]               q_y0,
   input  logic [COORD_BITS-1:0]               q_x1,
   input  logic [COORD_BITS-1:0]               q_y1,
   input  logic [COORD_BITS:0]                 q_dx,
   input  logic [COORD_BITS:0]                 q_dy,
   input  logic                                q_sxn,
   input  logic                                q_syn,
   input  logic [blsp_pkg::COLOR_BITS-1:0]     q_color,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,  // on_screen
   output logic                                rsp_tlast,  // last
   output logic [2*blsp_pkg::INDEX_BITS-1:0]   rsp_tdata,  // cell_index, cell_word
   output blsp_pkg::status_type                status
);

   localparam int C     = COORD_BITS;
   localparam int CMP_W = COORD_BITS + blsp_pkg::DIM_BITS;

   // line state
   logic active_ff, active_in;
   logic [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [C:0] dx_ff, dx_in, dy_ff, dy_in;
   logic sxn_ff, sxn_in, syn_ff, syn_in;
   logic signed [C+1:0] err_ff, err_in;
   logic [blsp_pkg::COLOR_BITS-1:0] color_ff, color_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic on_ff, on_in;
   logic last_ff, last_in;
   logic [blsp_pkg::INDEX_BITS-1:0] index_ff, index_in;
   logic [blsp_pkg::INDEX_BITS-1:0] word_ff, word_in;

   logic out_free, is_start, emit;
   logic on_screen, at_end, step_x, step_y;
   logic [CMP_W-1:0] prod, cell_sum;
   logic signed [C+2:0] e2, dx_ext, dy_ext, err_ext, err_sum;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_start = (q_cmd == blsp_pkg::CMD_START);
   // an advance with a line running needs room in the result register
   assign q_pop = q_valid && (is_start || !active_ff || out_free);
   assign emit  = q_pop && !is_start && active_ff;

   // point classification and cell index
   always_comb begin
      on_screen = !cur_x_ff[C-1] && !cur_y_ff[C-1]
               && (CMP_W'(cur_x_ff) < CMP_W'(screen_width))
               && (CMP_W'(cur_y_ff) < CMP_W'(screen_height));
      prod      = CMP_W'(cur_y_ff) * CMP_W'(screen_width);
      cell_sum  = prod + CMP_W'(cur_x_ff);
      at_end    = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);
   end

   // one bresenham step
   always_comb begin
      dx_ext  = $signed({2'b00, dx_ff});
      dy_ext  = $signed({2'b00, dy_ff});
      err_ext = $signed({err_ff[C+1], err_ff});
      e2      = $signed({err_ff, 1'b0});
      step_x  = (e2 > -dy_ext);
      step_y  = (e2 < dx_ext);
      err_sum = err_ext - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
   end

   // next line state
   always_comb begin
      active_in = active_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sxn_in    = sxn_ff;
      syn_in    = syn_ff;
      err_in    = err_ff;
      color_in  = color_ff;
      if (q_pop && is_start) begin
         active_in = 1'b1;
         cur_x_in  = q_x0;
         cur_y_in  = q_y0;
         goal_x_in = q_x1;
         goal_y_in = q_y1;
         dx_in     = q_dx;
         dy_in     = q_dy;
         sxn_in    = q_sxn;
         syn_in    = q_syn;
         err_in    = $signed({1'b0, q_dx}) - $signed({1'b0, q_dy});
         color_in  = q_color;
      end else if (emit) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            err_in = err_sum[C+1:0];
            if (step_x) begin
               cur_x_in = sxn_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (step_y) begin
               cur_y_in = syn_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   // next result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      on_in        = on_ff;
      last_in      = last_ff;
      index_in     = index_ff;
      word_in      = word_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         on_in        = on_screen;
         last_in      = at_end;
         index_in     = on_screen ? cell_sum[blsp_pkg::INDEX_BITS-1:0] : '0;
         word_in      = {color_ff, blsp_pkg::GLYPH_BLOCK};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      goal_x_ff <= goal_x_in;
      goal_y_ff <= goal_y_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sxn_ff    <= sxn_in;
      syn_ff    <= syn_in;
      err_ff    <= err_in;
      color_ff  <= color_in;
      on_ff     <= on_in;
      last_ff   <= last_in;
      index_ff  <= index_in;
      word_ff   <= word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = on_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {word_ff, index_ff};

   assign status.active    = active_ff;
   assign status.out_stall = !out_free;

endmodule

/* rtl/bresenham_line_stepper.sv */
// Bresenham line stepper for a character-cell screen.
// Input words (req_) carry a command in tuser: start loads two signed
// endpoints and a color and gives no result; advance emits the current
// point of the running line and steps once toward the endpoint. An advance
// with no line running is consumed and dropped; a start drops a running line.
// Result words (rsp_) carry the cell index and the cell word in tdata,
// the on-screen flag in tuser and the endpoint mark in tlast.
// An accepted advance word is first written into the two-entry command
// queue, and its point is registered in the result register as it leaves.
// Throughput: one word per cycle while the result side is not stalled, set
// by the step and the result register, which take a new point while the
// previous one drains.
// When rsp_tready is low the result holds and an advance on a running line
// waits at the head of the queue; a start or an advance with no line running
// at the head still drains, and req_tready drops once the queue is full.
// Reset clears the queue, the result register and the running line, and
// sets the screen to 80 columns by 25 rows. Screen size is written through
// the csr_ port at byte addresses 0 (width) and 4 (height).
module bresenham_line_stepper #(
   parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEF,
   parameter int REQ_DATA_W = ((4 * COORD_BITS + blsp_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // command
   // x_start, y_start, x_end, y_end, color
   input  logic [REQ_DATA_W-1:0]               req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,  // on_screen
   output logic                                rsp_tlast,  // last
   output logic [2*blsp_pkg::INDEX_BITS-1:0]   rsp_tdata,  // cell_index, cell_word
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [blsp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [blsp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [blsp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [blsp_pkg::DIM_BITS-1:0] width_ff, width_in;
   logic [blsp_pkg::DIM_BITS-1:0] height_ff, height_in;
   blsp_pkg::csr_reg_type csr_reg;
   logic csr_write;

   logic q_valid, q_pop, q_sxn, q_syn;
   blsp_pkg::cmd_type q_cmd;
   logic [COORD_BITS-1:0] q_x0, q_y0, q_x1, q_y1;
   logic [COORD_BITS:0] q_dx, q_dy;
   logic [blsp_pkg::COLOR_BITS-1:0] q_color;
   blsp_pkg::status_type status;

   // register file
   assign csr_pready = 1'b1;
   assign csr_reg    = blsp_pkg::csr_reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_reg)
            blsp_pkg::REG_WIDTH:  width_in  = csr_pwdata[blsp_pkg::DIM_BITS-1:0];
            blsp_pkg::REG_HEIGHT: height_in = csr_pwdata[blsp_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
      case (csr_reg)
         blsp_pkg::REG_HEIGHT: csr_prdata = blsp_pkg::CSR_DATA_BITS'(height_ff);
         default:              csr_prdata = blsp_pkg::CSR_DATA_BITS'(width_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blsp_pkg::WIDTH_RESET;
         height_ff <= blsp_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // command intake and queue
   blsp_front #(
      .COORD_BITS (COORD_BITS),
      .REQ_DATA_W (REQ_DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .q_x0       (q_x0),
      .q_y0       (q_y0),
      .q_x1       (q_x1),
      .q_y1       (q_y1),
      .q_dx       (q_dx),
      .q_dy       (q_dy),
      .q_sxn      (q_sxn),
      .q_syn      (q_syn),
      .q_color    (q_color)
   );

   // line stepping and result register
   blsp_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_cmd         (q_cmd),
      .q_x0          (q_x0),
      .q_y0          (q_y0),
      .q_x1          (q_x1),
      .q_y1          (q_y1),
      .q_dx          (q_dx),
      .q_dy          (q_dy),
      .q_sxn         (q_sxn),
      .q_syn         (q_syn),
      .q_color       (q_color),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .rsp_tdata     (rsp_tdata),
      .status        (status)
   );

   // the back end only takes what the queue holds
   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // a point is never taken while an earlier result is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd == blsp_pkg::CMD_ADVANCE && status.active) |-> !status.out_stall)
      else $error("result register overwritten while stalled");

   // a start always leaves a line running
   a_start_activates: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd == blsp_pkg::CMD_START) |=> status.active)
      else $error("start did not activate the line");

   // a new result appears only for an advance on a running line
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid && !rsp_tready)) |->
         $past(q_pop && q_cmd == blsp_pkg::CMD_ADVANCE && status.active))
      else $error("result without an advance");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int COORD_W   = blsp_pkg::COORD_BITS_DEF;
   localparam int COLOR_W   = blsp_pkg::COLOR_BITS;
   localparam int IDX_W     = blsp_pkg::INDEX_BITS;
   localparam int DIM_W     = blsp_pkg::DIM_BITS;
   localparam int REQ_W     = ((4 * COORD_W + COLOR_W + 7) / 8) * 8;
   localparam int COORD_MIN = -(1 << (COORD_W - 1));
   localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
   localparam int PHASE_WORDS  = 145;
   localparam int SETTLE_TICKS = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // one rasterized point as it leaves the block
   typedef struct {
      logic             on_screen;
      logic [15:0]      cell_index;
      logic [15:0]      cell_word;
      logic             last;
   } cell_point_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic                     req_tuser = 1'b0;            // command
   logic [REQ_W-1:0]         req_tdata = '0;              // x_start, y_start, x_end, y_end, color
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     rsp_tuser;                   // on_screen
   logic                     rsp_tlast;                   // last
   logic [2*IDX_W-1:0]       rsp_tdata;                   // cell_index, cell_word
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [blsp_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [blsp_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [blsp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // shadow of the line walker
   logic [DIM_W-1:0]      scr_w = blsp_pkg::WIDTH_RESET;
   logic [DIM_W-1:0]      scr_h = blsp_pkg::HEIGHT_RESET;
   logic                  line_live = 1'b0;
   int                    pos_x = 0, pos_y = 0, end_x = 0, end_y = 0;
   int                    span_x = 0, span_y = 0, err_acc = 0;
   logic                  walk_x_neg = 1'b0, walk_y_neg = 1'b0;
   logic [COLOR_W-1:0]    ink = '0;

   cell_point_type expected_points[$];

   int errors = 0;
   int cycles = 0;
   int words_sent = 0;
   int lines_started = 0;
   int points_checked = 0;
   int points_off = 0;
   int line_ends = 0;
   int screens_used = 1;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   bresenham_line_stepper i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d points still expected", cycles,
                expected_points.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // walk the shadow line for one accepted word
   function automatic void rasterize_word(blsp_pkg::cmd_type cmd, logic [REQ_W-1:0] data);
      cell_point_type pt;
      int        x0, y0, x1, y1, e2;
      if (cmd == blsp_pkg::CMD_START) begin
         x0 = $signed(data[0 +: COORD_W]);
         y0 = $signed(data[COORD_W +: COORD_W]);
         x1 = $signed(data[2*COORD_W +: COORD_W]);
         y1 = $signed(data[3*COORD_W +: COORD_W]);
         pos_x = x0;
         pos_y = y0;
         end_x = x1;
         end_y = y1;
         span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
         span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
         walk_x_neg = !(x0 < x1);
         walk_y_neg = !(y0 < y1);
         err_acc = span_x - span_y;
         ink = data[4*COORD_W +: COLOR_W];
         line_live = 1'b1;
         return;
      end
      // advance with no line running is dropped
      if (!line_live)
         return;
      pt.on_screen = pos_x >= 0 && pos_x < int'(scr_w) && pos_y >= 0 && pos_y < int'(scr_h);
      pt.cell_index = pt.on_screen ? 16'(pos_y * int'(scr_w) + pos_x) : 16'd0;
      pt.cell_word = {ink, blsp_pkg::GLYPH_BLOCK};
      pt.last = (pos_x == end_x) && (pos_y == end_y);
      expected_points.push_back(pt);
      if (pt.last) begin
         line_live = 1'b0;
      end else begin
         e2 = 2 * err_acc;
         if (e2 > -span_y) begin
            err_acc -= span_y;
            pos_x += walk_x_neg ? -1 : 1;
         end
         if (e2 < span_x) begin
            err_acc += span_x;
            pos_y += walk_y_neg ? -1 : 1;
         end
      end
   endfunction

   function automatic logic [REQ_W-1:0] pack_line(int x0, int y0, int x1, int y1,
                                                  logic [COLOR_W-1:0] color);
      logic [COORD_W-1:0] a, b, c, d;
      a = COORD_W'(x0);
      b = COORD_W'(y0);
      c = COORD_W'(x1);
      d = COORD_W'(y1);
      pack_line = '0;
      pack_line[0 +: COORD_W] = a;
      pack_line[COORD_W +: COORD_W] = b;
      pack_line[2*COORD_W +: COORD_W] = c;
      pack_line[3*COORD_W +: COORD_W] = d;
      pack_line[4*COORD_W +: COLOR_W] = color;
   endfunction

   function automatic int clamp_coord(int v);
      return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   // result side: check each word, then pick the next ready
   always @(posedge clock) begin
      cell_point_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.on_screen = rsp_tuser;
         got.cell_index = rsp_tdata[0 +: IDX_W];
         got.cell_word = rsp_tdata[IDX_W +: IDX_W];
         got.last = rsp_tlast;
         if (expected_points.size() == 0) begin
            $error("result word with nothing expected: index %0d word %h", got.cell_index,
                   got.cell_word);
            errors++;
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (!got.on_screen) points_off++;
            if (got.last) line_ends++;
            if (got.on_screen !== want.on_screen) begin
               $error("on_screen: expected %0d, got %0d", want.on_screen, got.on_screen);
               errors++;
            end
            if (got.cell_index !== want.cell_index) begin
               $error("cell_index: expected %0d, got %0d", want.cell_index, got.cell_index);
               errors++;
            end
            if (got.cell_word !== want.cell_word) begin
               $error("cell_word: expected %h, got %h", want.cell_word, got.cell_word);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // send one word, idling first at the current rate
   task automatic send_word(blsp_pkg::cmd_type cmd, logic [REQ_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      rasterize_word(cmd, data);
      words_sent++;
   endtask

   task automatic send_start(int x0, int y0, int x1, int y1, logic [COLOR_W-1:0] color);
      lines_started++;
      send_word(blsp_pkg::CMD_START, pack_line(x0, y0, x1, y1, color));
   endtask

   // payload of an advance is don't-care, so fill it with noise
   task automatic send_advance();
      logic [REQ_W-1:0] junk;
      junk = REQ_W'({$urandom, $urandom});
      send_word(blsp_pkg::CMD_ADVANCE, junk);
   endtask

   // stop sending and wait until every expected point is out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(blsp_pkg::csr_reg_type which, logic [DIM_W-1:0] value,
                            bit junk_high);
      logic [blsp_pkg::CSR_DATA_BITS-1:0] word;
      word = junk_high ? (($urandom & ~32'h1FF) | value) : blsp_pkg::CSR_DATA_BITS'(value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (which == blsp_pkg::REG_WIDTH) scr_w = value;
      else scr_h = value;
   endtask

   // well-formed lines near the screen, with abandoned lines, stray advances and noise
   task automatic run_lines(int n_words, int reach);
      int x0, y0, x1, y1, len, adv, kind, first;
      bit paused;
      first = words_sent;
      paused = 0;
      while (words_sent - first < n_words) begin
         if (!paused && words_sent - first >= n_words / 2) begin
            drain_results();
            paused = 1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            send_start($urandom_range(0, 4095) + COORD_MIN, $urandom_range(0, 4095) + COORD_MIN,
                       $urandom_range(0, 4095) + COORD_MIN, $urandom_range(0, 4095) + COORD_MIN,
                       COLOR_W'($urandom_range(0, 255)));
            adv = $urandom_range(0, 6);
         end else if (kind < 11) begin
            adv = 1;
         end else begin
            x0 = int'($urandom_range(0, int'(scr_w) + 7)) - 4;
            y0 = int'($urandom_range(0, int'(scr_h) + 7)) - 4;
            x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
            len = (((x1 > x0) ? x1 - x0 : x0 - x1) > ((y1 > y0) ? y1 - y0 : y0 - y1)) ?
                  ((x1 > x0) ? x1 - x0 : x0 - x1) + 1 : ((y1 > y0) ? y1 - y0 : y0 - y1) + 1;
            send_start(x0, y0, x1, y1, COLOR_W'($urandom_range(0, 255)));
            kind = $urandom_range(0, 9);
            if (kind == 0) adv = $urandom_range(0, len - 1);
            else if (kind == 1) adv = len + $urandom_range(1, 3);
            else adv = len;
         end
         for (int k = 0; k < adv; k++) send_advance();
      end
   endtask

   task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int s_idle,
                            int r_idle, int reach);
      drain_results();
      csr_write(blsp_pkg::REG_WIDTH, w, 1'($urandom_range(0, 1)));
      csr_write(blsp_pkg::REG_HEIGHT, h, 1'($urandom_range(0, 1)));
      screens_used++;
      send_idle_pct = s_idle;
      recv_stall_pct = r_idle;
      run_lines(PHASE_WORDS, reach);
   endtask

   // idle advance, single points, extreme endpoints, abandoned lines
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_advance();
      send_start(5, 3, 5, 3, 8'h00);
      send_advance();
      send_advance();
      send_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 8'hFF);
      repeat (3) send_advance();
      send_start(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 8'hA5);
      repeat (2) send_advance();
      send_start(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 8'h5A);
      send_advance();
      send_start(3, 3, 0, 0, 8'h81);
      repeat (4) send_advance();
      send_start(79, 24, 79, 24, 8'h7E);
      send_advance();
   endtask

   // one-cell screen, zero width, zero height
   task automatic test_tiny_screens();
      run_phase(9'd1, 9'd1, 0, 0, 4);
      run_phase(9'd0, 9'd25, 77, 0, 8);
      run_phase(9'd40, 9'd0, 0, 77, 8);
   endtask

   // largest square screen the index covers and sizes past it; at 511 by 511 the index wraps
   task automatic test_wide_screens();
      run_phase(9'd256, 9'd256, 12, 12, 12);
      run_phase(9'd511, 9'd511, 0, 0, 12);
      run_phase(9'd300, 9'd200, 0, 77, 12);
   endtask

   task automatic test_random_screens();
      run_phase(DIM_W'($urandom_range(1, 256)), DIM_W'($urandom_range(1, 256)), 77, 0, 12);
      run_phase(DIM_W'($urandom_range(0, 511)), DIM_W'($urandom_range(0, 511)), 12, 12, 12);
      run_phase(blsp_pkg::WIDTH_RESET, blsp_pkg::HEIGHT_RESET, 0, 0, 30);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tiny_screens();
      test_wide_screens();
      test_random_screens();
      drain_results();
      $display("summary: %0d words sent, %0d line starts, %0d screen sizes", words_sent,
               lines_started, screens_used);
      $display("summary: %0d points checked, %0d off screen, %0d line ends", points_checked,
               points_off, line_ends);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* bresenham_line_stepper.f */
rtl/blsp_pkg.sv
rtl/blsp_front.sv
rtl/blsp_back.sv
rtl/bresenham_line_stepper.sv
tb/sv/tb.sv
